>>> sv/rqsi_pkg.sv
package rqsi_pkg;

  localparam int unsigned QueueDepth = 128;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IdxWidth   = $clog2(QueueDepth);
  localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SORTED = 2'd1,
    CMD_POP    = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SORTED,
    CELL_POP
  } cell_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] head_value;
    logic [7:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    cell_op_e              op;
    logic [ValueWidth-1:0] value;
    logic [CntWidth-1:0]   count;
  } cell_ctrl_t;

endpackage

>>> sv/ring_queue_with_sorted_insert.sv
// The result of an accepted command appears on rsp_o, marked by valid_o, in the cycle
// after the command is accepted.
// Throughput: one command per cycle; busy stays low, since all cells update in parallel.
// The receiver cannot stall; each result word is shown for exactly one cycle.
// Reset clears the entry count, the status and the strobe; cell contents are undefined until written.
module ring_queue_with_sorted_insert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rqsi_pkg::req_t req_i,
  output logic           valid_o,
  output rqsi_pkg::rsp_t rsp_o
);
  import rqsi_pkg::*;

  logic [CntWidth-1:0]   count_q, count_d;
  logic                  valid_q;
  status_e               status_q, status_d;
  cell_ctrl_t            ctrl;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [QueueDepth:0]   found_w;
  logic [ValueWidth-1:0] val_w [QueueDepth];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_q == CntWidth'(QueueDepth);
  assign empty  = count_q == '0;

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = ValueWidth'(req_i.value);
    ctrl.count = count_q;
    count_d    = count_q;
    status_d   = ST_DONE;
    if (accept) begin
      case (cmd_e'(req_i.cmd))
        CMD_APPEND, CMD_SORTED: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = (cmd_e'(req_i.cmd) == CMD_APPEND) ? CELL_APPEND : CELL_SORTED;
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op = CELL_POP;
            count_d = count_q - 1'b1;
          end
        end
        default: status_d = ST_DONE;
      endcase
    end
  end

  assign found_w[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [ValueWidth-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = val_w[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_next
      assign right_v = val_w[i+1];
    end
    rqsi_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IdxWidth'(i)),
      .left_i  (left_v),
      .right_i (right_v),
      .found_i (found_w[i]),
      .found_o (found_w[i+1]),
      .val_o   (val_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      count_q  <= count_d;
      valid_q  <= accept;
      status_q <= status_d;
    end
  end

  assign valid_o           = valid_q;
  assign rsp_o.head_value  = empty ? 32'd0 : 32'(val_w[0]);
  assign rsp_o.entry_count = 8'(count_q);
  assign rsp_o.is_empty    = empty;
  assign rsp_o.status      = status_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(QueueDepth))
    else $error("entry count exceeds queue depth");

  a_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted command produced no result");

  a_full_refuse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && (req_i.cmd == CMD_APPEND || req_i.cmd == CMD_SORTED))
    |=> (rsp_o.status == ST_FULL && $stable(count_q)))
    else $error("push to full queue not refused");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !empty && req_i.cmd == CMD_POP)
    |=> (count_q == $past(count_q) - 1'b1 && rsp_o.status == ST_DONE))
    else $error("pop did not reduce entry count");

endmodule

>>> sv/rqsi_cell.sv
module rqsi_cell (
  input  logic                           clk_i,
  input  rqsi_pkg::cell_ctrl_t           ctrl_i,
  input  logic [rqsi_pkg::IdxWidth-1:0]  idx_i,
  input  logic [rqsi_pkg::ValueWidth-1:0] left_i,
  input  logic [rqsi_pkg::ValueWidth-1:0] right_i,
  input  logic                           found_i,
  output logic                           found_o,
  output logic [rqsi_pkg::ValueWidth-1:0] val_o
);
  import rqsi_pkg::*;

  logic [ValueWidth-1:0] val_q, val_d;
  logic                  occupied;
  logic                  greater;
  logic                  at_tail;

  assign occupied = CntWidth'(idx_i) < ctrl_i.count;
  assign at_tail  = CntWidth'(idx_i) == ctrl_i.count;
  assign greater  = occupied && (ctrl_i.value < val_q);
  assign found_o  = found_i | greater;
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_APPEND: begin
        if (at_tail) val_d = ctrl_i.value;
      end
      CELL_SORTED: begin
        if (found_i) begin
          val_d = left_i;
        end else if (greater || at_tail) begin
          val_d = ctrl_i.value;
        end
      end
      CELL_POP: val_d = right_i;
      default:  val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
